// ===== hdl/prsw_pkg.sv =====
// prsw_pkg: shared types, codes and constants for the portal ray sector walk
// used by prsw_ctrl, prsw_dp and portal_ray_sector_walk; no dependencies
package prsw_pkg;

	// field widths fixed by the interface
	localparam int SEC_ID_W  = 8;
	localparam int EDGE_ID_W = 4;
	localparam int XY_W      = 32;
	localparam int NB_W      = 9;
	localparam int VC_W      = 5;
	localparam int DIR_W     = 16;
	localparam int CMD_W     = 2;

	// default sizes
	localparam int DEF_MAX_SECTORS = 256;
	localparam int DEF_MAX_VERTS   = 16;
	localparam int DEF_MAX_HOPS    = 64;

	// arithmetic constants (epsilons in lsb of the Q18.14 ray parameter)
	localparam int T_EPS     = 7;
	localparam int ADV_EPS   = 66;
	localparam int DIV_BITS  = 32;
	localparam int MUL_STEPS = 6;
	localparam int STEP_W    = 5;

	typedef enum logic [CMD_W-1:0] {
		CMD_WRITE_VERT = 2'd0,
		CMD_SET_COUNT  = 2'd1,
		CMD_QUERY      = 2'd2,
		CMD_NOP        = 2'd3
	} cmd_code_t;

	typedef enum logic [4:0] {
		OP_IDLE,
		OP_WR_VERT,
		OP_WR_CNT,
		OP_START,
		OP_CNT_RD,
		OP_CNT_LD,
		OP_VA_RD,
		OP_VA_LD,
		OP_VB_RD,
		OP_VB_LD,
		OP_DIFF,
		OP_MUL,
		OP_EVAL,
		OP_CHK,
		OP_DIV,
		OP_HIT,
		OP_NEXTE,
		OP_ADV_MX,
		OP_ADV_AX,
		OP_ADV_AY,
		OP_OUT
	} dp_op_t;

	typedef enum logic [4:0] {
		ST_IDLE,
		ST_HOP,
		ST_CNT,
		ST_VA_RD,
		ST_VA_LD,
		ST_VB_RD,
		ST_VB_LD,
		ST_DIFF,
		ST_MUL,
		ST_EVAL,
		ST_CHK,
		ST_DIV,
		ST_HIT,
		ST_NEXTE,
		ST_ENDH,
		ST_ADVX,
		ST_ADVY,
		ST_DONE
	} state_t;

	typedef struct packed {
		dp_op_t             op;
		logic [STEP_W-1:0]  step;
	} dp_cmd_t;

	typedef struct packed {
		logic sec_ok;
		logic n_lt2;
		logic last_edge;
		logic skip;
		logic sat;
		logic found;
		logic wall;
	} dp_sts_t;

endpackage

// ===== hdl/portal_ray_sector_walk.sv =====
// portal_ray_sector_walk: top level of the portal sector ray walker
// depends on prsw_pkg, prsw_ctrl, prsw_dp (and prsw_ram below it)
//
//   channel | handshake            | payload
//   in      | in_valid / in_stall  | command, sector_id, edge_id, vertex_x/y, neighbor,
//           |                      | vertex_count, origin_x/y, dir_x/y
//   out     | out_valid / out_stall| picked_sector
//
// a write word is taken while idle; a query word holds the input stalled until
// its walk is done: per hop a count read and first vertex load, then per edge a
// store read, six products through the one shared multiplier and, if needed, a
// 32 step restoring divider, then an origin advance; a final step loads the
// result register
// reset clears the sector count valid bits, so every count reads zero; vertex
// stores are undefined until written
// a finished result sits in the output register; the next word is taken while
// it waits, and a later query only blocks if that result is still not taken
module portal_ray_sector_walk #(
	parameter int MAX_SECTORS = prsw_pkg::DEF_MAX_SECTORS,
	parameter int MAX_VERTS   = prsw_pkg::DEF_MAX_VERTS,
	parameter int MAX_HOPS    = prsw_pkg::DEF_MAX_HOPS
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 in_valid,
	output logic                                 in_stall,
	input  logic [prsw_pkg::CMD_W-1:0]           command,
	input  logic [prsw_pkg::SEC_ID_W-1:0]        sector_id,
	input  logic [prsw_pkg::EDGE_ID_W-1:0]       edge_id,
	input  logic signed [prsw_pkg::XY_W-1:0]     vertex_x,
	input  logic signed [prsw_pkg::XY_W-1:0]     vertex_y,
	input  logic signed [prsw_pkg::NB_W-1:0]     neighbor,
	input  logic [prsw_pkg::VC_W-1:0]            vertex_count,
	input  logic signed [prsw_pkg::XY_W-1:0]     origin_x,
	input  logic signed [prsw_pkg::XY_W-1:0]     origin_y,
	input  logic signed [prsw_pkg::DIR_W-1:0]    dir_x,
	input  logic signed [prsw_pkg::DIR_W-1:0]    dir_y,
	output logic                                 out_valid,
	input  logic                                 out_stall,
	output logic [prsw_pkg::SEC_ID_W-1:0]        picked_sector
);

	// command and status between sequencer and datapath
	prsw_pkg::dp_cmd_t dp_cmd;
	prsw_pkg::dp_sts_t dp_sts;

	// sequencer: handshakes, hop count, per edge step and divider bit counts
	prsw_ctrl #(.MAX_HOPS(MAX_HOPS)) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.command   (command),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.cmd       (dp_cmd),
		.sts       (dp_sts)
	);

	// datapath: map stores, edge math, divider, origin advance, result register
	prsw_dp #(
		.MAX_SECTORS (MAX_SECTORS),
		.MAX_VERTS   (MAX_VERTS)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (dp_cmd),
		.sts           (dp_sts),
		.sector_id     (sector_id),
		.edge_id       (edge_id),
		.vertex_x      (vertex_x),
		.vertex_y      (vertex_y),
		.neighbor      (neighbor),
		.vertex_count  (vertex_count),
		.origin_x      (origin_x),
		.origin_y      (origin_y),
		.dir_x         (dir_x),
		.dir_y         (dir_y),
		.picked_sector (picked_sector)
	);

endmodule

// ===== hdl/prsw_ram.sv =====
// prsw_ram: generic simple dual port ram, one write and one registered read
// no dependencies
module prsw_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// ===== hdl/prsw_dp.sv =====
// prsw_dp: datapath of the ray walk, map stores, shared multiplier, divider
// depends on prsw_pkg and prsw_ram
module prsw_dp #(
	parameter int MAX_SECTORS = prsw_pkg::DEF_MAX_SECTORS,
	parameter int MAX_VERTS   = prsw_pkg::DEF_MAX_VERTS
) (
	input  logic                                    clk,
	input  logic                                    arst_n,
	input  prsw_pkg::dp_cmd_t                       cmd,
	output prsw_pkg::dp_sts_t                       sts,
	input  logic [prsw_pkg::SEC_ID_W-1:0]           sector_id,
	input  logic [prsw_pkg::EDGE_ID_W-1:0]          edge_id,
	input  logic signed [prsw_pkg::XY_W-1:0]        vertex_x,
	input  logic signed [prsw_pkg::XY_W-1:0]        vertex_y,
	input  logic signed [prsw_pkg::NB_W-1:0]        neighbor,
	input  logic [prsw_pkg::VC_W-1:0]               vertex_count,
	input  logic signed [prsw_pkg::XY_W-1:0]        origin_x,
	input  logic signed [prsw_pkg::XY_W-1:0]        origin_y,
	input  logic signed [prsw_pkg::DIR_W-1:0]       dir_x,
	input  logic signed [prsw_pkg::DIR_W-1:0]       dir_y,
	output logic [prsw_pkg::SEC_ID_W-1:0]           picked_sector
);

	localparam int NSEC  = (MAX_SECTORS < 256) ? MAX_SECTORS : 256;
	localparam int SEC_W = (NSEC > 1) ? $clog2(NSEC) : 1;
	localparam int VW    = (MAX_VERTS > 1) ? $clog2(MAX_VERTS) : 1;
	localparam int CW    = $clog2(MAX_VERTS + 1);
	localparam int VDEP  = NSEC * MAX_VERTS;
	localparam int AW    = $clog2(VDEP);
	localparam int XW    = prsw_pkg::XY_W;
	localparam int NBW   = prsw_pkg::NB_W;
	localparam int VRW   = NBW + 2 * XW;
	localparam int OPW   = XW + 2;
	localparam int PW    = 2 * OPW;
	localparam int DENW  = 50;
	localparam int NTW   = 67;
	localparam int REMW  = 50;
	localparam int SUMW  = XW + 3;
	localparam int DIV_BITS_L = prsw_pkg::DIV_BITS;
	localparam int VC_WL = prsw_pkg::VC_W;

	function automatic logic signed [XW-1:0] sat32(input logic signed [SUMW-1:0] v);
		logic signed [SUMW-1:0] hi;
		logic signed [SUMW-1:0] lo;
		hi = SUMW'({1'b0, {(XW-1){1'b1}}});
		lo = ~hi;
		if (v > hi) begin
			return hi[XW-1:0];
		end else if (v < lo) begin
			return lo[XW-1:0];
		end
		return v[XW-1:0];
	endfunction

	// query registers
	logic signed [XW-1:0]         px_q, py_q;
	logic signed [prsw_pkg::DIR_W-1:0] dx_q, dy_q;
	logic [prsw_pkg::SEC_ID_W-1:0] sec_q;
	logic [prsw_pkg::SEC_ID_W-1:0] picked_q;
	logic [CW-1:0]                n_q;
	logic [VW-1:0]                e_q;
	logic signed [XW-1:0]         ax_q, ay_q, bx_q, by_q;
	logic [NBW-1:0]               nba_q, nbb_q;
	logic signed [XW:0]           rx_q, ry_q, ex_q, ey_q;
	logic signed [PW-1:0]         prod_s1;
	logic signed [DENW-1:0]       den_q, nu_q;
	logic signed [NTW-1:0]        nt_q;
	logic [REMW-1:0]              rem_q;
	logic [DIV_BITS_L-1:0]        dl_q, q_q;
	logic                         sat_q;
	logic                         found_q;
	logic [DIV_BITS_L-1:0]        best_q;
	logic [NBW-1:0]               bnb_q;
	logic [NSEC-1:0]              cvld_q;
	logic                         cvld_s1;

	// store ports
	logic                 v_we;
	logic [AW-1:0]        v_waddr, v_raddr;
	logic [VRW-1:0]       v_wdata, v_rdata;
	logic                 c_we;
	logic [SEC_W-1:0]     c_waddr, c_raddr;
	logic [CW-1:0]        c_wdata, c_rdata;

	logic [SEC_W-1:0]     sec_idx;
	logic [VW-1:0]        rd_idx;
	logic                 last_edge;
	logic signed [OPW-1:0] ma, mb;
	logic signed [PW-1:0]  prod;
	logic [XW:0]          adv_t;
	logic signed [SUMW-1:0] adv_sum;
	logic                 skip;
	logic                 sat;
	logic [REMW:0]        div_t;
	logic                 div_ge;
	logic [DIV_BITS_L-1:0] tq;
	logic [VC_WL-1:0]     vc;

	assign sec_idx   = sec_q[SEC_W-1:0];
	assign last_edge = ((CW'(e_q) + CW'(1)) == n_q);
	assign rd_idx    = (cmd.op == prsw_pkg::OP_VA_RD || last_edge) ? '0 : (e_q + VW'(1));
	assign vc        = vertex_count;

	assign v_we    = (cmd.op == prsw_pkg::OP_WR_VERT) && (int'(sector_id) < MAX_SECTORS)
		&& (int'(edge_id) < MAX_VERTS);
	assign v_waddr = AW'(AW'(sector_id[SEC_W-1:0]) * AW'(MAX_VERTS)) + AW'(VW'(edge_id));
	assign v_wdata = {neighbor, vertex_y, vertex_x};
	assign v_raddr = AW'(AW'(sec_idx) * AW'(MAX_VERTS)) + AW'(rd_idx);

	assign c_we    = (cmd.op == prsw_pkg::OP_WR_CNT) && (int'(sector_id) < MAX_SECTORS);
	assign c_waddr = sector_id[SEC_W-1:0];
	assign c_wdata = (int'(vc) > MAX_VERTS) ? CW'(MAX_VERTS) : CW'(vc);
	assign c_raddr = sec_idx;

	prsw_ram #(.WIDTH(VRW), .DEPTH(VDEP)) u_vram (
		.clk   (clk),
		.we    (v_we),
		.waddr (v_waddr),
		.wdata (v_wdata),
		.raddr (v_raddr),
		.rdata (v_rdata)
	);

	prsw_ram #(.WIDTH(CW), .DEPTH(NSEC)) u_cram (
		.clk   (clk),
		.we    (c_we),
		.waddr (c_waddr),
		.wdata (c_wdata),
		.raddr (c_raddr),
		.rdata (c_rdata)
	);

	// shared multiplier operand select
	assign adv_t = {1'b0, best_q} + (XW+1)'(prsw_pkg::ADV_EPS);
	always_comb begin
		ma = '0;
		mb = '0;
		case (cmd.op)
			prsw_pkg::OP_MUL: begin
				case (cmd.step)
					5'd0: begin ma = OPW'(dx_q); mb = OPW'(ey_q); end
					5'd1: begin ma = OPW'(dy_q); mb = OPW'(ex_q); end
					5'd2: begin ma = OPW'(rx_q); mb = OPW'(dy_q); end
					5'd3: begin ma = OPW'(ry_q); mb = OPW'(dx_q); end
					5'd4: begin ma = OPW'(rx_q); mb = OPW'(ey_q); end
					5'd5: begin ma = OPW'(ry_q); mb = OPW'(ex_q); end
					default: begin ma = '0; mb = '0; end
				endcase
			end
			prsw_pkg::OP_ADV_MX: begin ma = OPW'(dx_q); mb = $signed({1'b0, adv_t}); end
			prsw_pkg::OP_ADV_AX: begin ma = OPW'(dy_q); mb = $signed({1'b0, adv_t}); end
			default: begin ma = '0; mb = '0; end
		endcase
	end
	assign prod = ma * mb;

	// floor shift of the registered product, then add to the origin
	always_comb begin
		if (cmd.op == prsw_pkg::OP_ADV_AX) begin
			adv_sum = SUMW'(px_q) + SUMW'(prod_s1 >>> 14);
		end else begin
			adv_sum = SUMW'(py_q) + SUMW'(prod_s1 >>> 14);
		end
	end

	// edge rejection and quotient overflow, on normalized den, nu, nt
	assign skip = (den_q <= DENW'(1)) || nt_q[NTW-1] || (nt_q == '0) || nu_q[DENW-1]
		|| (nu_q > den_q);
	assign sat  = ({1'b0, nt_q[NTW-1:18]} >= den_q);

	assign div_t  = {rem_q, dl_q[DIV_BITS_L-1]};
	assign div_ge = (div_t >= (REMW+1)'(den_q));
	assign tq     = sat_q ? '1 : q_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cvld_q  <= '0;
			found_q <= 1'b0;
		end else begin
			if (c_we) begin
				cvld_q[c_waddr] <= 1'b1;
			end
			if (cmd.op == prsw_pkg::OP_CNT_RD) begin
				found_q <= 1'b0;
			end else if (cmd.op == prsw_pkg::OP_HIT && tq > DIV_BITS_L'(prsw_pkg::T_EPS)
				&& (!found_q || tq < best_q)) begin
				found_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		cvld_s1 <= cvld_q[sec_idx];
		unique case (cmd.op)
			prsw_pkg::OP_START: begin
				px_q  <= origin_x;
				py_q  <= origin_y;
				dx_q  <= dir_x;
				dy_q  <= dir_y;
				sec_q <= sector_id;
			end
			prsw_pkg::OP_CNT_LD: begin
				n_q <= cvld_s1 ? c_rdata : '0;
			end
			prsw_pkg::OP_VA_LD: begin
				ax_q  <= v_rdata[XW-1:0];
				ay_q  <= v_rdata[2*XW-1:XW];
				nba_q <= v_rdata[VRW-1:2*XW];
				e_q   <= '0;
			end
			prsw_pkg::OP_VB_LD: begin
				bx_q  <= v_rdata[XW-1:0];
				by_q  <= v_rdata[2*XW-1:XW];
				nbb_q <= v_rdata[VRW-1:2*XW];
			end
			prsw_pkg::OP_DIFF: begin
				rx_q <= (XW+1)'(ax_q) - (XW+1)'(px_q);
				ry_q <= (XW+1)'(ay_q) - (XW+1)'(py_q);
				ex_q <= (XW+1)'(bx_q) - (XW+1)'(ax_q);
				ey_q <= (XW+1)'(by_q) - (XW+1)'(ay_q);
			end
			prsw_pkg::OP_MUL: begin
				prod_s1 <= prod;
				case (cmd.step)
					5'd1: den_q <= prod_s1[DENW-1:0];
					5'd2: den_q <= den_q - prod_s1[DENW-1:0];
					5'd3: nu_q  <= prod_s1[DENW-1:0];
					5'd4: nu_q  <= nu_q - prod_s1[DENW-1:0];
					5'd5: nt_q  <= prod_s1[NTW-1:0];
					5'd6: nt_q  <= nt_q - prod_s1[NTW-1:0];
					default: ;
				endcase
			end
			prsw_pkg::OP_EVAL: begin
				if (den_q[DENW-1]) begin
					den_q <= -den_q;
					nu_q  <= -nu_q;
					nt_q  <= -nt_q;
				end
			end
			prsw_pkg::OP_CHK: begin
				sat_q <= sat;
				rem_q <= REMW'(nt_q[NTW-1:18]);
				dl_q  <= {nt_q[17:0], 14'd0};
				q_q   <= '0;
			end
			prsw_pkg::OP_DIV: begin
				rem_q <= div_ge ? REMW'(div_t - (REMW+1)'(den_q)) : REMW'(div_t);
				dl_q  <= {dl_q[DIV_BITS_L-2:0], 1'b0};
				q_q   <= {q_q[DIV_BITS_L-2:0], div_ge};
			end
			prsw_pkg::OP_HIT: begin
				if (tq > DIV_BITS_L'(prsw_pkg::T_EPS) && (!found_q || tq < best_q)) begin
					best_q <= tq;
					bnb_q  <= nba_q;
				end
			end
			prsw_pkg::OP_NEXTE: begin
				ax_q  <= bx_q;
				ay_q  <= by_q;
				nba_q <= nbb_q;
				e_q   <= e_q + VW'(1);
			end
			prsw_pkg::OP_ADV_MX: begin
				prod_s1 <= prod;
			end
			prsw_pkg::OP_ADV_AX: begin
				px_q    <= sat32(adv_sum);
				prod_s1 <= prod;
			end
			prsw_pkg::OP_ADV_AY: begin
				py_q  <= sat32(adv_sum);
				sec_q <= bnb_q[prsw_pkg::SEC_ID_W-1:0];
			end
			prsw_pkg::OP_OUT: begin
				picked_q <= sec_q;
			end
			default: ;
		endcase
	end

	assign sts.sec_ok    = (int'(sec_q) < MAX_SECTORS);
	assign sts.n_lt2     = (n_q < CW'(2));
	assign sts.last_edge = last_edge;
	assign sts.skip      = skip;
	assign sts.sat       = sat;
	assign sts.found     = found_q;
	assign sts.wall      = bnb_q[NBW-1];

	assign picked_sector = picked_q;

endmodule

// ===== hdl/prsw_ctrl.sv =====
// prsw_ctrl: sequencer for writes and ray walk queries, output valid flag
// depends on prsw_pkg
module prsw_ctrl #(
	parameter int MAX_HOPS = prsw_pkg::DEF_MAX_HOPS
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [prsw_pkg::CMD_W-1:0]    command,
	output logic                          out_valid,
	input  logic                          out_stall,
	output prsw_pkg::dp_cmd_t             cmd,
	input  prsw_pkg::dp_sts_t             sts
);

	localparam int HW = $clog2(MAX_HOPS + 1);

	prsw_pkg::state_t               state_q, state_d;
	logic [prsw_pkg::STEP_W-1:0]    cnt_q, cnt_d;
	logic [HW-1:0]                  hop_q, hop_d;
	logic                           out_valid_q, out_valid_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= prsw_pkg::ST_IDLE;
			cnt_q       <= '0;
			hop_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			cnt_q       <= cnt_d;
			hop_q       <= hop_d;
			out_valid_q <= out_valid_d;
		end
	end

	always_comb begin
		state_d     = state_q;
		cnt_d       = cnt_q;
		hop_d       = hop_q;
		out_valid_d = out_valid_q && out_stall;
		cmd.op      = prsw_pkg::OP_IDLE;
		cmd.step    = cnt_q;
		in_stall    = 1'b1;
		unique case (state_q)
			prsw_pkg::ST_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					case (prsw_pkg::cmd_code_t'(command))
						prsw_pkg::CMD_WRITE_VERT: cmd.op = prsw_pkg::OP_WR_VERT;
						prsw_pkg::CMD_SET_COUNT:  cmd.op = prsw_pkg::OP_WR_CNT;
						prsw_pkg::CMD_QUERY: begin
							cmd.op  = prsw_pkg::OP_START;
							hop_d   = '0;
							state_d = prsw_pkg::ST_HOP;
						end
						default: ;
					endcase
				end
			end
			prsw_pkg::ST_HOP: begin
				if (hop_q == HW'(MAX_HOPS) || !sts.sec_ok) begin
					state_d = prsw_pkg::ST_DONE;
				end else begin
					cmd.op  = prsw_pkg::OP_CNT_RD;
					state_d = prsw_pkg::ST_CNT;
				end
			end
			prsw_pkg::ST_CNT: begin
				cmd.op  = prsw_pkg::OP_CNT_LD;
				state_d = prsw_pkg::ST_VA_RD;
			end
			prsw_pkg::ST_VA_RD: begin
				if (sts.n_lt2) begin
					state_d = prsw_pkg::ST_DONE;
				end else begin
					cmd.op  = prsw_pkg::OP_VA_RD;
					state_d = prsw_pkg::ST_VA_LD;
				end
			end
			prsw_pkg::ST_VA_LD: begin
				cmd.op  = prsw_pkg::OP_VA_LD;
				state_d = prsw_pkg::ST_VB_RD;
			end
			prsw_pkg::ST_VB_RD: begin
				cmd.op  = prsw_pkg::OP_VB_RD;
				state_d = prsw_pkg::ST_VB_LD;
			end
			prsw_pkg::ST_VB_LD: begin
				cmd.op  = prsw_pkg::OP_VB_LD;
				state_d = prsw_pkg::ST_DIFF;
			end
			prsw_pkg::ST_DIFF: begin
				cmd.op  = prsw_pkg::OP_DIFF;
				cnt_d   = '0;
				state_d = prsw_pkg::ST_MUL;
			end
			prsw_pkg::ST_MUL: begin
				cmd.op = prsw_pkg::OP_MUL;
				if (cnt_q == prsw_pkg::STEP_W'(prsw_pkg::MUL_STEPS)) begin
					state_d = prsw_pkg::ST_EVAL;
				end else begin
					cnt_d = cnt_q + 1'b1;
				end
			end
			prsw_pkg::ST_EVAL: begin
				cmd.op  = prsw_pkg::OP_EVAL;
				state_d = prsw_pkg::ST_CHK;
			end
			prsw_pkg::ST_CHK: begin
				cmd.op = prsw_pkg::OP_CHK;
				cnt_d  = '0;
				if (sts.skip) begin
					state_d = prsw_pkg::ST_NEXTE;
				end else if (sts.sat) begin
					state_d = prsw_pkg::ST_HIT;
				end else begin
					state_d = prsw_pkg::ST_DIV;
				end
			end
			prsw_pkg::ST_DIV: begin
				cmd.op = prsw_pkg::OP_DIV;
				if (cnt_q == prsw_pkg::STEP_W'(prsw_pkg::DIV_BITS - 1)) begin
					state_d = prsw_pkg::ST_HIT;
				end else begin
					cnt_d = cnt_q + 1'b1;
				end
			end
			prsw_pkg::ST_HIT: begin
				cmd.op  = prsw_pkg::OP_HIT;
				state_d = prsw_pkg::ST_NEXTE;
			end
			prsw_pkg::ST_NEXTE: begin
				cmd.op  = prsw_pkg::OP_NEXTE;
				state_d = sts.last_edge ? prsw_pkg::ST_ENDH : prsw_pkg::ST_VB_RD;
			end
			prsw_pkg::ST_ENDH: begin
				if (!sts.found || sts.wall) begin
					state_d = prsw_pkg::ST_DONE;
				end else begin
					cmd.op  = prsw_pkg::OP_ADV_MX;
					state_d = prsw_pkg::ST_ADVX;
				end
			end
			prsw_pkg::ST_ADVX: begin
				cmd.op  = prsw_pkg::OP_ADV_AX;
				state_d = prsw_pkg::ST_ADVY;
			end
			prsw_pkg::ST_ADVY: begin
				cmd.op  = prsw_pkg::OP_ADV_AY;
				hop_d   = hop_q + 1'b1;
				state_d = prsw_pkg::ST_HOP;
			end
			prsw_pkg::ST_DONE: begin
				if (!out_valid_q || !out_stall) begin
					cmd.op      = prsw_pkg::OP_OUT;
					out_valid_d = 1'b1;
					state_d     = prsw_pkg::ST_IDLE;
				end
			end
			default: state_d = prsw_pkg::ST_IDLE;
		endcase
	end

	assign out_valid = out_valid_q;

endmodule

// ===== test/portal_ray_sector_walk_tb.sv =====
// portal_ray_sector_walk_tb: self-checking testbench for the portal sector ray walker
// builds sector maps, casts rays and checks each picked sector against a local predictor
// depends on prsw_pkg and portal_ray_sector_walk
module portal_ray_sector_walk_tb;

	localparam int NSEC     = prsw_pkg::DEF_MAX_SECTORS;
	localparam int NVERT    = prsw_pkg::DEF_MAX_VERTS;
	localparam int NHOPS    = prsw_pkg::DEF_MAX_HOPS;
	localparam int CELL     = 65536;   // grid cell edge, 1.0 in Q16.16
	localparam int GRID     = 8;       // grid of GRID x GRID square sectors
	localparam int DOG_MAX  = 250000;  // watchdog limit, well above the longest walk
	localparam int DRAIN    = 200;

	typedef struct {
		prsw_pkg::cmd_code_t cmd;
		logic [7:0]         sid;
		logic [3:0]         eid;
		logic signed [31:0] vx, vy;
		logic signed [8:0]  nb;
		logic [4:0]         vc;
		logic signed [31:0] ox, oy;
		logic signed [15:0] ddx, ddy;
		bit                 drain_first;  // hold this word until all results are back
	} map_word_t;

	logic                     clk, arst_n;
	logic                     in_valid, in_stall, out_valid, out_stall;
	logic [prsw_pkg::CMD_W-1:0] command;
	logic [7:0]               sector_id, picked_sector;
	logic [3:0]               edge_id;
	logic signed [31:0]       vertex_x, vertex_y, origin_x, origin_y;
	logic signed [8:0]        neighbor;
	logic [4:0]               vertex_count;
	logic signed [15:0]       dir_x, dir_y;

	portal_ray_sector_walk u_dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.command(command), .sector_id(sector_id), .edge_id(edge_id),
		.vertex_x(vertex_x), .vertex_y(vertex_y), .neighbor(neighbor),
		.vertex_count(vertex_count), .origin_x(origin_x), .origin_y(origin_y),
		.dir_x(dir_x), .dir_y(dir_y),
		.out_valid(out_valid), .out_stall(out_stall), .picked_sector(picked_sector)
	);

	// words waiting to be sent, and picked sectors still owed by the block
	map_word_t  word_q[$];
	logic [7:0] sector_due_q[$];

	// shadow of the sector map, updated as words are accepted
	int                map_x[NSEC*NVERT];
	int                map_y[NSEC*NVERT];
	logic signed [8:0] map_nb[NSEC*NVERT];
	int                map_cnt[NSEC];

	// generation side: which vertices exist once all queued words land
	bit gen_written[NSEC*NVERT];

	int n_err, n_words, n_rays, n_picked, max_hops_seen, dog;

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	function automatic longint clamp32(longint v);
		if (v > 64'sd2147483647) return 64'sd2147483647;
		if (v < -64'sd2147483648) return -64'sd2147483648;
		return v;
	endfunction

	// cast one ray through the shadow map and return where the walk stops
	function automatic logic [7:0] walk_ray(logic [7:0] start, logic signed [31:0] ox,
	                                        logic signed [31:0] oy, logic signed [15:0] ddx,
	                                        logic signed [15:0] ddy, output int hops);
		longint px, py, dx, dy, ax, ay, ex, ey, rx, ry, den, nu, tq, best;
		logic signed [127:0] nt, quo, w_rx, w_ry, w_ex, w_ey;
		int n, ka, kb, bw, sec, hop;
		bit found;
		px = ox; py = oy; dx = ddx; dy = ddy;
		sec = start;
		hops = 0;
		for (hop = 0; hop < NHOPS; hop++) begin
			n = map_cnt[sec];
			found = 0; best = 0; bw = 0;
			for (int w = 0; w < n; w++) begin
				ka = sec*NVERT + w;
				kb = sec*NVERT + (w + 1) % n;
				ax = map_x[ka]; ay = map_y[ka];
				ex = longint'(map_x[kb]) - ax;
				ey = longint'(map_y[kb]) - ay;
				rx = ax - px; ry = ay - py;
				den = dx*ey - dy*ex;
				nu = rx*dy - ry*dx;
				if (den >= -1 && den <= 1) continue;  // parallel edge
				w_rx = rx; w_ry = ry; w_ex = ex; w_ey = ey;
				nt = w_rx*w_ey - w_ry*w_ex;
				if (den < 0) begin
					den = -den; nu = -nu; nt = -nt;
				end
				if (nt <= 0 || nu < 0 || nu > den) continue;
				quo = (nt <<< 14) / den;
				tq = (quo > 128'sh0FFFFFFFF) ? 64'sh0FFFFFFFF : longint'(quo);
				if (tq > prsw_pkg::T_EPS && (!found || tq < best)) begin
					found = 1; best = tq; bw = w;
				end
			end
			if (!found) break;
			if (map_nb[sec*NVERT + bw] < 0) break;  // solid wall
			sec = int'(map_nb[sec*NVERT + bw]) & 8'hFF;
			hops++;
			px = clamp32(px + ((dx * (best + prsw_pkg::ADV_EPS)) >>> 14));
			py = clamp32(py + ((dy * (best + prsw_pkg::ADV_EPS)) >>> 14));
		end
		return sec[7:0];
	endfunction

	// ---------------- word generation ----------------

	function automatic map_word_t blank_word(prsw_pkg::cmd_code_t c, int s);
		map_word_t w;
		w.cmd = c; w.sid = s[7:0]; w.eid = '0; w.vx = '0; w.vy = '0; w.nb = '0;
		w.vc = '0; w.ox = '0; w.oy = '0; w.ddx = '0; w.ddy = '0; w.drain_first = 0;
		return w;
	endfunction

	task automatic put_vertex(int s, int e, int x, int y, int nb);
		map_word_t w;
		w = blank_word(prsw_pkg::CMD_WRITE_VERT, s);
		w.eid = e[3:0]; w.vx = x; w.vy = y; w.nb = nb[8:0];
		gen_written[s*NVERT + e] = 1;
		word_q.push_back(w);
	endtask

	// only counts whose vertices all exist are ever set, so no walk reads an empty slot
	task automatic put_count(int s, int c);
		map_word_t w;
		int eff;
		eff = (c > NVERT) ? NVERT : c;
		for (int e = 0; e < eff; e++)
			if (!gen_written[s*NVERT + e]) put_vertex(s, e, 0, 0, -1);
		w = blank_word(prsw_pkg::CMD_SET_COUNT, s);
		w.vc = c[4:0];
		word_q.push_back(w);
	endtask

	task automatic put_ray(int s, int x, int y, int ddx, int ddy);
		map_word_t w;
		w = blank_word(prsw_pkg::CMD_QUERY, s);
		w.ox = x; w.oy = y; w.ddx = ddx[15:0]; w.ddy = ddy[15:0];
		word_q.push_back(w);
	endtask

	function automatic int rand_dir();
		return int'($urandom_range(0, 32768)) - 16384;
	endfunction

	function automatic int rand_nb();
		case ($urandom_range(0, 3))
			0: return -1;
			1: return -int'($urandom_range(1, 256));
			default: return int'($urandom_range(0, 255));
		endcase
	endfunction

	// square cells with portals to their four neighbors and a few inner walls
	task automatic build_grid();
		int s, x0, y0, nbs[4];
		for (int j = 0; j < GRID; j++)
			for (int i = 0; i < GRID; i++) begin
				s = j*GRID + i;
				x0 = (i - GRID/2) * CELL;
				y0 = (j - GRID/2) * CELL;
				nbs[0] = (j > 0)      ? s - GRID : -1;
				nbs[1] = (i < GRID-1) ? s + 1    : -1;
				nbs[2] = (j < GRID-1) ? s + GRID : -1;
				nbs[3] = (i > 0)      ? s - 1    : -1;
				for (int e = 0; e < 4; e++)
					if ($urandom_range(0, 9) == 0) nbs[e] = -1;
				put_vertex(s, 0, x0,        y0,        nbs[0]);
				put_vertex(s, 1, x0 + CELL, y0,        nbs[1]);
				put_vertex(s, 2, x0 + CELL, y0 + CELL, nbs[2]);
				put_vertex(s, 3, x0,        y0 + CELL, nbs[3]);
				put_count(s, 4);
			end
	endtask

	task automatic grid_ray();
		int i, j;
		i = $urandom_range(0, GRID-1);
		j = $urandom_range(0, GRID-1);
		put_ray(j*GRID + i, (i - GRID/2)*CELL + int'($urandom_range(1, CELL-1)),
		        (j - GRID/2)*CELL + int'($urandom_range(1, CELL-1)), rand_dir(), rand_dir());
	endtask

	// a free-form sector with random vertices, links into the rest of the map, and a ray into it
	task automatic noise_sector();
		int s, n, span;
		s = $urandom_range(GRID*GRID, NSEC-1);
		n = ($urandom_range(0, 7) == 0) ? $urandom_range(6, NVERT) : $urandom_range(3, 5);
		span = ($urandom_range(0, 3) == 0) ? 0 : 8*CELL;
		for (int e = 0; e < n; e++) begin
			if (span == 0) put_vertex(s, e, $urandom, $urandom, rand_nb());
			else put_vertex(s, e, int'($urandom_range(0, 2*span)) - span,
			                int'($urandom_range(0, 2*span)) - span, rand_nb());
		end
		put_count(s, (n == NVERT) ? int'($urandom_range(NVERT, 31)) : n);
		put_ray(s, int'($urandom_range(0, 2*CELL)) - CELL, int'($urandom_range(0, 2*CELL)) - CELL,
		        rand_dir(), rand_dir());
	endtask

	task automatic directed_words();
		map_word_t w;
		put_ray(5, 0, 0, 16384, 0);                        // empty sector keeps the ray
		// huge triangle at the coordinate extremes, two kinds of wall and a portal
		put_vertex(1, 0, 32'h8000_0000, 32'h8000_0000, -1);
		put_vertex(1, 1, 32'h7FFF_FFFF, 32'h8000_0000, -256);
		put_vertex(1, 2, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 255);
		put_count(1, 3);
		put_ray(1, 0, 0, 16384, 0);
		put_ray(1, 0, 0, -16384, 16384);
		put_ray(1, 0, 0, 0, -16384);
		put_ray(1, 0, 0, 0, 0);                            // zero direction
		put_ray(1, 32'h8000_0000, 32'h7FFF_FFFF, 16384, -16384);
		put_ray(1, 32'h7FFF_FFFF, 32'h8000_0000, -16384, -1);
		// single-vertex and two-vertex sectors
		put_vertex(2, 0, CELL, CELL, 1);
		put_count(2, 1);
		put_ray(2, 0, 0, 16384, 16384);
		put_vertex(3, 0, -CELL, CELL, 1);
		put_vertex(3, 1, CELL, CELL, 2);
		put_count(3, 2);
		put_ray(3, 0, 0, 0, 16384);
		put_count(3, 0);
		put_ray(3, 0, 0, 0, 16384);
		w = blank_word(prsw_pkg::CMD_NOP, 1);              // ignored command
		w.vc = 5'h1F; w.eid = 4'hF;
		word_q.push_back(w);
		put_ray(1, 0, 0, 16384, 0);
	endtask

	// ---------------- input side ----------------

	map_word_t cur;
	int        gap_left;
	bit        hold;
	int        ray_hops;
	logic [7:0] due;

	always_comb hold = (word_q.size() > 0) && word_q[0].drain_first
	                   && (sector_due_q.size() > 0 || out_valid);

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			command <= '0; sector_id <= '0; edge_id <= '0; vertex_x <= '0; vertex_y <= '0;
			neighbor <= '0; vertex_count <= '0; origin_x <= '0; origin_y <= '0;
			dir_x <= '0; dir_y <= '0;
			gap_left <= 0;
		end else begin
			if (in_valid && !in_stall) begin
				n_words++;
				case (cur.cmd)
					prsw_pkg::CMD_WRITE_VERT: begin
						map_x[cur.sid*NVERT + cur.eid] = cur.vx;
						map_y[cur.sid*NVERT + cur.eid] = cur.vy;
						map_nb[cur.sid*NVERT + cur.eid] = cur.nb;
					end
					prsw_pkg::CMD_SET_COUNT:
						map_cnt[cur.sid] = (cur.vc > NVERT) ? NVERT : cur.vc;
					prsw_pkg::CMD_QUERY: begin
						due = walk_ray(cur.sid, cur.ox, cur.oy, cur.ddx, cur.ddy, ray_hops);
						sector_due_q.push_back(due);
						n_rays++;
						if (ray_hops > max_hops_seen) max_hops_seen = ray_hops;
					end
					default: ;
				endcase
			end
			// load the next word once the current one is gone
			if (!in_valid || !in_stall) begin
				if (gap_left > 0) begin
					in_valid <= 1'b0;
					gap_left <= gap_left - 1;
				end else if (word_q.size() > 0 && !hold) begin
					cur = word_q.pop_front();
					command <= cur.cmd; sector_id <= cur.sid; edge_id <= cur.eid;
					vertex_x <= cur.vx; vertex_y <= cur.vy; neighbor <= cur.nb;
					vertex_count <= cur.vc; origin_x <= cur.ox; origin_y <= cur.oy;
					dir_x <= cur.ddx; dir_y <= cur.ddy;
					in_valid <= 1'b1;
					// every fourth run of 32 words goes back to back
					gap_left <= (n_words[6:5] == 2'd0) ? 0 : int'($urandom_range(0, 15));
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// ---------------- output side ----------------

	int stall_left;
	int next_stall;
	logic [7:0] exp_sector;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
			stall_left <= 0;
		end else begin
			next_stall = stall_left;
			if (out_valid && !out_stall) begin
				n_picked++;
				if (sector_due_q.size() == 0) begin
					$error("picked_sector: no word expected, actual %0d", picked_sector);
					n_err++;
				end else begin
					exp_sector = sector_due_q.pop_front();
					if (picked_sector !== exp_sector) begin
						$error("picked_sector: expected %0d, actual %0d", exp_sector,
						       picked_sector);
						n_err++;
					end
				end
				next_stall = (n_picked[5:4] == 2'd0) ? 0 : int'($urandom_range(0, 15));
			end
			if (next_stall > 0) begin
				out_stall <= 1'b1;
				stall_left <= next_stall - 1;
			end else begin
				out_stall <= 1'b0;
				stall_left <= 0;
			end
		end
	end

	// watchdog: cycles with no word moving on either channel
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) dog <= 0;
		else if ((in_valid && !in_stall) || (out_valid && !out_stall)) dog <= 0;
		else begin
			dog <= dog + 1;
			if (dog >= DOG_MAX) begin
				$display("watchdog expired with %0d results outstanding", sector_due_q.size());
				$display("CHECKS FAILED");
				$finish;
			end
		end
	end

	// ---------------- sequence ----------------

	initial begin
		map_word_t w;
		n_err = 0; n_words = 0; n_rays = 0; n_picked = 0; max_hops_seen = 0;
		foreach (map_cnt[k]) map_cnt[k] = 0;
		foreach (map_x[k]) begin
			map_x[k] = 0; map_y[k] = 0; map_nb[k] = '0; gen_written[k] = 0;
		end
		directed_words();
		build_grid();
		// first grid ray waits until the directed results are all back
		w = blank_word(prsw_pkg::CMD_QUERY, 0);
		w.ddx = 16'sd16384; w.ox = -4*CELL + 100; w.oy = -4*CELL + 100;
		w.drain_first = 1;
		word_q.push_back(w);
		while (word_q.size() < 780) begin
			case ($urandom_range(0, 9))
				0, 1, 2, 3, 4: grid_ray();
				5, 6: noise_sector();
				7: put_ray($urandom_range(0, NSEC-1), $urandom, $urandom, rand_dir(), rand_dir());
				8: begin  // stray write to a free sector
					put_vertex($urandom_range(GRID*GRID, NSEC-1), $urandom_range(0, NVERT-1),
					           $urandom, $urandom, rand_nb());
				end
				default: begin
					w = blank_word(prsw_pkg::CMD_NOP, $urandom_range(0, NSEC-1));
					w.vx = $urandom; w.ox = $urandom;
					word_q.push_back(w);
				end
			endcase
		end

		arst_n = 1'b0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		while (word_q.size() != 0 || in_valid || sector_due_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN) @(posedge clk);

		$display("sent %0d words, %0d rays; longest walk %0d hops; %0d results taken",
		         n_words, n_rays, max_hops_seen, n_picked);
		if (n_err == 0 && sector_due_q.size() == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule

// ===== portal_ray_sector_walk.f =====
hdl/prsw_pkg.sv
hdl/prsw_ram.sv
hdl/prsw_dp.sv
hdl/prsw_ctrl.sv
hdl/portal_ray_sector_walk.sv
test/portal_ray_sector_walk_tb.sv
